// File: hw/rtl/cmaa_pkg.sv
package cmaa_pkg;

    localparam int MASK_MAX_WIDTH_DEF  = 256;
    localparam int MASK_MAX_HEIGHT_DEF = 256;
    localparam int CANVAS_MAX_DIM_DEF  = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y      = 3'd6;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] COLOR_KEEP_MASK = 32'hffffff00;
    localparam logic [7:0]  ALPHA_FULL      = 8'd255;

    typedef struct packed {
        logic               enable;
        logic [12:0]        cnv_cols;
        logic [12:0]        cnv_rows;
        logic [8:0]         msk_cols;
        logic [8:0]         msk_rows;
        logic signed [13:0] offset_x;
        logic signed [13:0] offset_y;
    } cfg_t;

    typedef struct packed {
        logic        is_load;
        logic        in_mask;
        logic        last;
        logic [7:0]  wdata;
        logic [31:0] color;
    } op_meta_t;

    // exact floor(p / 255) for p < 65280
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] sum;
        sum = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return sum[15:8];
    endfunction

endpackage

// File: hw/rtl/clipping_mask_alpha_apply.sv
// channel   dir  handshake               payload
// pixel     in   pix_valid / pix_stall   func, mask_alpha, mask_present, in_color
// result    out  res_valid / res_stall   out_color, frame_last
// config    in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle sustained while res_stall is low; a canvas pixel's result passes
// through the input stage, queue, store read and multiply registers in that order.
// A mask load gives no result; it writes the store when it is popped from the queue.
// Reset clears control only; mask store contents are undefined until loaded.
// res_stall holds the output stage; pressure backs up through a four-entry queue
// to pix_stall, so the front keeps taking pixels while a result waits.
module clipping_mask_alpha_apply
    import cmaa_pkg::*;
#(
    parameter int MASK_MAX_WIDTH  = MASK_MAX_WIDTH_DEF,
    parameter int MASK_MAX_HEIGHT = MASK_MAX_HEIGHT_DEF,
    parameter int CANVAS_MAX_DIM  = CANVAS_MAX_DIM_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic                  func,
    input  logic [7:0]            mask_alpha,
    input  logic                  mask_present,
    input  logic [31:0]           in_color,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [31:0]           out_color,
    output logic                  frame_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STORE_DEPTH = MASK_MAX_WIDTH * MASK_MAX_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int Q_W         = $bits(op_meta_t) + ADDR_W;

    cfg_t              cfg_reg, cfg_next;
    logic              q_push, q_full, q_pop, q_valid;
    logic [ADDR_W-1:0] push_addr, pop_addr;
    op_meta_t          push_meta, pop_meta;
    logic [Q_W-1:0]    pop_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ENABLE:        cfg_next.enable   = cfg_data[0];
                CFG_CANVAS_WIDTH:  cfg_next.cnv_cols = cfg_data[12:0];
                CFG_CANVAS_HEIGHT: cfg_next.cnv_rows = cfg_data[12:0];
                CFG_MASK_WIDTH:    cfg_next.msk_cols = cfg_data[8:0];
                CFG_MASK_HEIGHT:   cfg_next.msk_rows = cfg_data[8:0];
                CFG_OFFSET_X:      cfg_next.offset_x = cfg_data[13:0];
                CFG_OFFSET_Y:      cfg_next.offset_y = cfg_data[13:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable   <= 1'b0;
            cfg_reg.cnv_cols <= 13'd1;
            cfg_reg.cnv_rows <= 13'd1;
            cfg_reg.msk_cols <= 9'd1;
            cfg_reg.msk_rows <= 9'd1;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cmaa_front #(
        .MASK_MAX_WIDTH  (MASK_MAX_WIDTH),
        .MASK_MAX_HEIGHT (MASK_MAX_HEIGHT),
        .CANVAS_MAX_DIM  (CANVAS_MAX_DIM),
        .ADDR_W          (ADDR_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .func         (func),
        .mask_alpha   (mask_alpha),
        .mask_present (mask_present),
        .in_color     (in_color),
        .q_push       (q_push),
        .q_addr       (push_addr),
        .q_meta       (push_meta),
        .q_full       (q_full)
    );

    cmaa_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   ({push_meta, push_addr}),
        .full      (q_full),
        .pop       (q_pop),
        .rd_data   (pop_data),
        .not_empty (q_valid)
    );

    assign pop_meta = pop_data[Q_W-1:ADDR_W];
    assign pop_addr = pop_data[ADDR_W-1:0];

    cmaa_back #(
        .MASK_MAX_WIDTH  (MASK_MAX_WIDTH),
        .MASK_MAX_HEIGHT (MASK_MAX_HEIGHT),
        .ADDR_W          (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (cfg_reg.enable),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_addr     (pop_addr),
        .q_meta     (pop_meta),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_color  (out_color),
        .frame_last (frame_last)
    );

endmodule

// File: hw/rtl/cmaa_fifo.sv
module cmaa_fifo
    import cmaa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (not_empty && (count_reg == $past(count_reg) + CNT_W'(1))))
        else $error("queue count lost a push");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");
`endif

endmodule

// File: hw/rtl/cmaa_front.sv
module cmaa_front
    import cmaa_pkg::*;
#(
    parameter int MASK_MAX_WIDTH  = MASK_MAX_WIDTH_DEF,
    parameter int MASK_MAX_HEIGHT = MASK_MAX_HEIGHT_DEF,
    parameter int CANVAS_MAX_DIM  = CANVAS_MAX_DIM_DEF,
    parameter int ADDR_W          = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  logic              func,
    input  logic [7:0]        mask_alpha,
    input  logic              mask_present,
    input  logic [31:0]       in_color,
    output logic              q_push,
    output logic [ADDR_W-1:0] q_addr,
    output op_meta_t          q_meta,
    input  logic              q_full
);

    localparam int CNT_W   = (CANVAS_MAX_DIM > 1) ? $clog2(CANVAS_MAX_DIM) : 1;
    localparam int CDIM_W  = ($clog2(CANVAS_MAX_DIM + 1) > 13) ?
                             $clog2(CANVAS_MAX_DIM + 1) : 13;
    localparam int MMAX    = (MASK_MAX_WIDTH > MASK_MAX_HEIGHT) ?
                             MASK_MAX_WIDTH : MASK_MAX_HEIGHT;
    localparam int MDIM_W  = ($clog2(MMAX + 1) > 9) ? $clog2(MMAX + 1) : 9;
    localparam int MXW     = (MASK_MAX_WIDTH > 1) ? $clog2(MASK_MAX_WIDTH) : 1;
    localparam int MYW     = (MASK_MAX_HEIGHT > 1) ? $clog2(MASK_MAX_HEIGHT) : 1;
    localparam int PX_W    = ((14 > CNT_W + 1) ? 14 : CNT_W + 1) + 1;
    localparam int XC_W    = (PX_W - 1 > MDIM_W) ? PX_W - 1 : MDIM_W;
    localparam int SZ_W    = 2 * MDIM_W;

    logic [CDIM_W-1:0] cw, ch;
    logic [MDIM_W-1:0] mw, mh;
    logic              accept;
    logic              col_end, row_end;
    logic signed [PX_W-1:0] mx, my;
    logic              inside_x, inside_y;
    logic [SZ_W-1:0]   load_inc, mask_size;

    logic [ADDR_W-1:0] load_idx_reg, load_idx_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  row_reg, row_next;
    logic              f1_valid_reg, f1_valid_next;
    op_meta_t          f1_meta_reg;
    logic [ADDR_W-1:0] f1_laddr_reg;
    logic [MXW-1:0]    f1_mx_reg;
    logic [MYW-1:0]    f1_my_reg;

    always_comb
    begin
        if (cfg.cnv_cols == '0)
            cw = CDIM_W'(1);
        else if (CDIM_W'(cfg.cnv_cols) > CDIM_W'(CANVAS_MAX_DIM))
            cw = CDIM_W'(CANVAS_MAX_DIM);
        else
            cw = CDIM_W'(cfg.cnv_cols);

        if (cfg.cnv_rows == '0)
            ch = CDIM_W'(1);
        else if (CDIM_W'(cfg.cnv_rows) > CDIM_W'(CANVAS_MAX_DIM))
            ch = CDIM_W'(CANVAS_MAX_DIM);
        else
            ch = CDIM_W'(cfg.cnv_rows);

        if (cfg.msk_cols == '0)
            mw = MDIM_W'(1);
        else if (MDIM_W'(cfg.msk_cols) > MDIM_W'(MASK_MAX_WIDTH))
            mw = MDIM_W'(MASK_MAX_WIDTH);
        else
            mw = MDIM_W'(cfg.msk_cols);

        if (cfg.msk_rows == '0)
            mh = MDIM_W'(1);
        else if (MDIM_W'(cfg.msk_rows) > MDIM_W'(MASK_MAX_HEIGHT))
            mh = MDIM_W'(MASK_MAX_HEIGHT);
        else
            mh = MDIM_W'(cfg.msk_rows);
    end

    assign pix_stall = f1_valid_reg && q_full;
    assign accept    = pix_valid && !pix_stall;

    assign col_end = (CDIM_W'(col_reg) + CDIM_W'(1)) >= cw;
    assign row_end = (CDIM_W'(row_reg) + CDIM_W'(1)) >= ch;

    assign mx = $signed({{(PX_W - 14){cfg.offset_x[13]}}, cfg.offset_x})
              + $signed({{(PX_W - CNT_W){1'b0}}, col_reg});
    assign my = $signed({{(PX_W - 14){cfg.offset_y[13]}}, cfg.offset_y})
              + $signed({{(PX_W - CNT_W){1'b0}}, row_reg});

    assign inside_x = !mx[PX_W-1] && (XC_W'(mx[PX_W-2:0]) < XC_W'(mw));
    assign inside_y = !my[PX_W-1] && (XC_W'(my[PX_W-2:0]) < XC_W'(mh));

    assign load_inc  = SZ_W'(load_idx_reg) + SZ_W'(1);
    assign mask_size = SZ_W'(mw) * SZ_W'(mh);

    always_comb
    begin
        load_idx_next = load_idx_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (accept)
        begin
            if (!func)
            begin
                load_idx_next = (load_inc >= mask_size) ? '0 : load_inc[ADDR_W-1:0];
            end
            else if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        if (accept)
            f1_valid_next = 1'b1;
        else if (q_push)
            f1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            load_idx_reg <= load_idx_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_meta_reg.is_load <= !func;
            f1_meta_reg.in_mask <= inside_x && inside_y;
            f1_meta_reg.last    <= col_end && row_end;
            f1_meta_reg.wdata   <= mask_present ? mask_alpha : 8'd0;
            f1_meta_reg.color   <= in_color;
            f1_laddr_reg        <= load_idx_reg;
            f1_mx_reg           <= mx[MXW-1:0];
            f1_my_reg           <= my[MYW-1:0];
        end
    end

    // row-major store address, exact because it stays below the store depth
    assign q_push = f1_valid_reg && !q_full;
    assign q_meta = f1_meta_reg;
    assign q_addr = f1_meta_reg.is_load ? f1_laddr_reg :
                    ADDR_W'(f1_my_reg) * ADDR_W'(mw) + ADDR_W'(f1_mx_reg);

endmodule

// File: hw/rtl/cmaa_back.sv
module cmaa_back
    import cmaa_pkg::*;
#(
    parameter int MASK_MAX_WIDTH  = MASK_MAX_WIDTH_DEF,
    parameter int MASK_MAX_HEIGHT = MASK_MAX_HEIGHT_DEF,
    parameter int ADDR_W          = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic              q_valid,
    output logic              q_pop,
    input  logic [ADDR_W-1:0] q_addr,
    input  op_meta_t          q_meta,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [31:0]       out_color,
    output logic              frame_last
);

    localparam int STORE_DEPTH = MASK_MAX_WIDTH * MASK_MAX_HEIGHT;

    logic [7:0]  store_mem [STORE_DEPTH];
    logic [7:0]  rd_data_reg;
    logic        b_valid_reg, b_valid_next;
    op_meta_t    b_meta_reg;
    logic        c_valid_reg, c_valid_next;
    op_meta_t    c_meta_reg;
    logic [15:0] c_prod_reg;
    logic        b_adv, c_adv;
    logic [7:0]  alpha_m;

    assign c_adv = !c_valid_reg || !res_stall;
    assign b_adv = !b_valid_reg || c_adv;
    assign q_pop = q_valid && b_adv;

    // disabled: scaling by 255 leaves the alpha byte as it is
    assign alpha_m = !enable ? ALPHA_FULL : (b_meta_reg.in_mask ? rd_data_reg : 8'd0);

    always_comb
    begin
        b_valid_next = b_valid_reg;
        c_valid_next = c_valid_reg;
        if (b_adv)
            b_valid_next = q_pop && !q_meta.is_load;
        if (c_adv)
            c_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (q_meta.is_load)
                store_mem[q_addr] <= q_meta.wdata;
            else
                rd_data_reg <= store_mem[q_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
            b_meta_reg <= q_meta;
        if (c_adv && b_valid_reg)
        begin
            c_meta_reg <= b_meta_reg;
            c_prod_reg <= 16'(b_meta_reg.color[7:0]) * 16'(alpha_m);
        end
    end

    assign res_valid  = c_valid_reg;
    assign out_color  = (c_meta_reg.color & COLOR_KEEP_MASK) | {24'd0, div255(c_prod_reg)};
    assign frame_last = c_meta_reg.last;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

import cmaa_pkg::*;

typedef enum bit {
    FUNC_LOAD_MASK    = 1'b0,
    FUNC_CANVAS_PIXEL = 1'b1
} pix_func_e;

typedef struct {
    logic [31:0] color;
    logic        frame_end;
} clipped_pixel_t;

class alpha_clip_scoreboard;
    bit                 enable;
    logic [12:0]        canvas_w;
    logic [12:0]        canvas_h;
    logic [8:0]         mask_w;
    logic [8:0]         mask_h;
    logic signed [13:0] off_x;
    logic signed [13:0] off_y;

    logic [7:0]  mask_alpha_mem [MASK_MAX_WIDTH_DEF*MASK_MAX_HEIGHT_DEF];
    int unsigned load_pos;
    int unsigned col;
    int unsigned row;

    clipped_pixel_t clipped_pixels_due[$];

    function new();
        enable   = 1'b0;
        canvas_w = 13'd1;
        canvas_h = 13'd1;
        mask_w   = 9'd1;
        mask_h   = 9'd1;
        off_x    = '0;
        off_y    = '0;
        load_pos = 0;
        col      = 0;
        row      = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function int unsigned mask_cols();
        return clamp_dim(mask_w, MASK_MAX_WIDTH_DEF);
    endfunction

    function int unsigned mask_rows();
        return clamp_dim(mask_h, MASK_MAX_HEIGHT_DEF);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLE:        enable   = data[0];
            CFG_CANVAS_WIDTH:  canvas_w = data[12:0];
            CFG_CANVAS_HEIGHT: canvas_h = data[12:0];
            CFG_MASK_WIDTH:    mask_w   = data[8:0];
            CFG_MASK_HEIGHT:   mask_h   = data[8:0];
            CFG_OFFSET_X:      off_x    = data[13:0];
            CFG_OFFSET_Y:      off_y    = data[13:0];
            default: ;
        endcase
    endfunction

    // one accepted transfer on the pixel channel
    function void note_transfer(bit f, logic [7:0] alpha, bit present, logic [31:0] color);
        int unsigned    mw;
        int unsigned    mh;
        int unsigned    cw;
        int unsigned    ch;
        int unsigned    pos;
        int             mx;
        int             my;
        logic [7:0]     ma;
        logic [15:0]    prod;
        bit             col_end;
        bit             row_end;
        clipped_pixel_t r;

        mw = mask_cols();
        mh = mask_rows();
        if (f == FUNC_LOAD_MASK)
        begin
            pos = load_pos % (MASK_MAX_WIDTH_DEF * MASK_MAX_HEIGHT_DEF);
            mask_alpha_mem[pos] = present ? alpha : 8'd0;
            load_pos = (pos + 1 >= mw * mh) ? 0 : pos + 1;
            return;
        end

        cw = clamp_dim(canvas_w, CANVAS_MAX_DIM_DEF);
        ch = clamp_dim(canvas_h, CANVAS_MAX_DIM_DEF);
        mx = int'(off_x) + int'(col);
        my = int'(off_y) + int'(row);
        ma = 8'd0;
        if (mx >= 0 && mx < int'(mw) && my >= 0 && my < int'(mh))
            ma = mask_alpha_mem[my * int'(mw) + mx];

        r.color = color;
        if (enable)
        begin
            prod = color[7:0] * ma;
            r.color[7:0] = 8'(prod / 255);
        end
        col_end     = (col + 1 >= cw);
        row_end     = (row + 1 >= ch);
        r.frame_end = col_end && row_end;
        clipped_pixels_due.push_back(r);

        if (col_end)
        begin
            col = 0;
            row = row_end ? 0 : row + 1;
        end
        else
        begin
            col = col + 1;
        end
    endfunction

    // empty string when the result matches
    function string check_result(logic [31:0] color, logic frame_end);
        clipped_pixel_t e;
        string          s;

        if (clipped_pixels_due.size() == 0)
            return $sformatf("unexpected result out_color=%h frame_last=%b", color, frame_end);
        e = clipped_pixels_due.pop_front();
        s = "";
        if (color !== e.color)
            s = $sformatf("out_color %h, expected %h", color, e.color);
        if (frame_end !== e.frame_end)
            s = {s, $sformatf(" frame_last %b, expected %b", frame_end, e.frame_end)};
        return s;
    endfunction
endclass

module tb_top;

    localparam int ITEM_TARGET  = 1950;
    localparam int QUIET_AFTER  = 1650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 8;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  pix_valid    = 1'b0;
    logic                  pix_stall;
    logic                  func         = 1'b0;
    logic [7:0]            mask_alpha   = '0;
    logic                  mask_present = 1'b0;
    logic [31:0]           in_color     = '0;
    logic                  res_valid;
    logic                  res_stall    = 1'b0;
    logic [31:0]           out_color;
    logic                  frame_last;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    alpha_clip_scoreboard sb = new();

    int    errors      = 0;
    int    items_sent  = 0;
    int    cycle_count = 0;
    bit    tx_gaps     = 1'b0;
    bit    stall_on    = 1'b0;
    string mon_msg;

    clipping_mask_alpha_apply dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .func         (func),
        .mask_alpha   (mask_alpha),
        .mask_present (mask_present),
        .in_color     (in_color),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_color    (out_color),
        .frame_last   (frame_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("cycle limit reached");
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            mon_msg = sb.check_result(out_color, frame_last);
            if (mon_msg != "")
                report_mismatch(mon_msg);
        end
    end

    // receiver backpressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_on && rst_n && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_color();
        logic [31:0] c;
        c = $urandom();
        c[7:0] = pick_alpha();
        return c;
    endfunction

    task automatic send_item(bit f, logic [7:0] alpha, bit present, logic [31:0] color);
        pix_valid    <= 1'b1;
        func         <= f;
        mask_alpha   <= alpha;
        mask_present <= present;
        in_color     <= color;
        do @(posedge clk); while (pix_stall);
        sb.note_transfer(f, alpha, present, color);
        items_sent++;
    endtask

    // drops pix_valid, then waits on the clock as many times as the caller asks
    task automatic release_tx(int cycles);
        pix_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic after_item();
        if (tx_gaps && $urandom_range(0, 5) == 0)
            release_tx($urandom_range(1, 4));
    endtask

    task automatic go_idle();
        release_tx(1);
        while (sb.clipped_pixels_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(bit en, int cw, int ch, int mw, int mh, int ox, int oy);
        logic [CFG_DATA_W-1:0] vals [7];
        logic [CFG_IDX_W-1:0]  idx  [7];

        idx[0] = CFG_ENABLE;        vals[0] = CFG_DATA_W'(en);
        idx[1] = CFG_CANVAS_WIDTH;  vals[1] = CFG_DATA_W'(cw[12:0]);
        idx[2] = CFG_CANVAS_HEIGHT; vals[2] = CFG_DATA_W'(ch[12:0]);
        idx[3] = CFG_MASK_WIDTH;    vals[3] = CFG_DATA_W'(mw[8:0]);
        idx[4] = CFG_MASK_HEIGHT;   vals[4] = CFG_DATA_W'(mh[8:0]);
        idx[5] = CFG_OFFSET_X;      vals[5] = ox[13:0];
        idx[6] = CFG_OFFSET_Y;      vals[6] = oy[13:0];
        go_idle();
        for (int i = 0; i < 7; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // finish any partial mask, then write the whole one
    task automatic load_full_mask();
        int n;
        while (sb.load_pos != 0)
        begin
            send_item(FUNC_LOAD_MASK, pick_alpha(), $urandom_range(0, 7) != 0, $urandom());
            after_item();
        end
        n = sb.mask_cols() * sb.mask_rows();
        repeat (n)
        begin
            send_item(FUNC_LOAD_MASK, pick_alpha(), $urandom_range(0, 7) != 0, $urandom());
            after_item();
        end
    endtask

    task automatic run_phase(bit en, int cw, int ch, int mw, int mh, int ox, int oy,
                             int npix);
        program_regs(en, cw, ch, mw, mh, ox, oy);
        load_full_mask();
        repeat (npix)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(FUNC_LOAD_MASK, pick_alpha(), 1'($urandom_range(0, 1)),
                          $urandom());
            else
                send_item(FUNC_CANVAS_PIXEL, pick_alpha(), 1'($urandom_range(0, 1)),
                          pick_color());
            if ($urandom_range(0, 149) == 0)
            begin
                release_tx(1);
                while (sb.clipped_pixels_due.size() != 0) @(posedge clk);
            end
            else
            begin
                after_item();
            end
        end
    endtask

    task automatic directed_items();
        tx_gaps  = 1'b1;
        stall_on = 1'b1;

        // 2x2 mask, canvas shifted one column left of it
        program_regs(1'b1, 3, 2, 2, 2, -1, 0);
        send_item(FUNC_LOAD_MASK, 8'd255, 1'b1, 32'h0);
        send_item(FUNC_LOAD_MASK, 8'd0,   1'b1, 32'hffffffff);
        send_item(FUNC_LOAD_MASK, 8'd200, 1'b0, 32'h0);
        send_item(FUNC_LOAD_MASK, 8'd128, 1'b1, 32'h0);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'hffffffff);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'h123456ff);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'habcdef80);
        send_item(FUNC_CANVAS_PIXEL, 8'hff, 1'b1, 32'h000000ff);
        send_item(FUNC_CANVAS_PIXEL, 8'hff, 1'b1, 32'hffffff00);
        send_item(FUNC_CANVAS_PIXEL, 8'hff, 1'b1, 32'h80808001);

        // bypass, clamped sizes, extreme offsets
        program_regs(1'b0, 8191, 0, 0, 1, 8191, -8192);
        send_item(FUNC_LOAD_MASK, 8'd255, 1'b1, 32'h0);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'hffffffff);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'h00000000);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'h5a5a5a7f);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'ha5a5a580);

        // 1x1 canvas entered with the column counter past the end
        program_regs(1'b1, 1, 1, 1, 1, 0, 0);
        send_item(FUNC_LOAD_MASK, 8'd255, 1'b1, 32'h0);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'h000000ff);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'hffffff00);
        send_item(FUNC_CANVAS_PIXEL, 8'd0, 1'b0, 32'h1234567f);
    endtask

    task automatic random_items();
        bit en;
        int ox;
        int oy;

        run_phase(1'b1, 4096, 2, 256, 1, 200, 0, 60);
        run_phase(1'b1, 1, 4096, 1, 256, 0, 190, 80);
        run_phase(1'b1, 8191, 8191, 511, 0, -5, 0, 30);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_AFTER)
            begin
                tx_gaps  = 1'b0;
                stall_on = 1'b0;
            end
            else
            begin
                tx_gaps  = $urandom_range(0, 3) != 0;
                stall_on = $urandom_range(0, 3) != 0;
            end
            en = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) == 0)
            begin
                ox = int'($urandom_range(0, 16383)) - 8192;
                oy = int'($urandom_range(0, 16383)) - 8192;
            end
            else
            begin
                ox = int'($urandom_range(0, 16)) - 8;
                oy = int'($urandom_range(0, 16)) - 8;
            end
            run_phase(en, $urandom_range(0, 9), $urandom_range(0, 6),
                      $urandom_range(0, 9), $urandom_range(0, 9), ox, oy,
                      $urandom_range(20, 90));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        random_items();
        go_idle();

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
